// ----- rtl/core/cobs_crc_pkg.sv -----
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// COBS frame decoder. No dependencies.
package cobs_crc_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  CODE_MAX  = 8'hFF;
    localparam logic [8:0]  MIN_FRAME = 9'd5;
    localparam logic [8:0]  COUNT_MAX = 9'd511;
    localparam logic [8:0]  HDR_LAST  = 9'd2;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_TRUNC = 3'd2,
        ST_SHORT = 3'd3,
        ST_LEN   = 3'd4,
        ST_CRC   = 3'd5
    } status_t;

    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       eof;
        logic       empty;
        logic       trunc;
    } dec_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        logic [7:0] seq;
        logic [7:0] cmd;
        logic [7:0] len;
        status_t    status;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/cobs_crc_unstuff.sv -----
// COBS unstuffing: tracks the block countdown and the owed zero byte.
// Depends on cobs_crc_pkg.
module cobs_crc_unstuff
    import cobs_crc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] wire_byte,
    output dec_t       dec
);

    logic [7:0] block_remaining_reg, block_remaining_next;
    logic       zero_pending_reg, zero_pending_next;
    logic       raw_seen_reg, raw_seen_next;

    always_comb
    begin
        block_remaining_next = block_remaining_reg;
        zero_pending_next    = zero_pending_reg;
        raw_seen_next        = raw_seen_reg;
        dec.push             = 1'b0;
        dec.data             = 8'h00;
        dec.eof              = 1'b0;
        dec.empty            = !raw_seen_reg;
        dec.trunc            = (block_remaining_reg != 8'h00);
        if (step)
        begin
            if (wire_byte == 8'h00)
            begin
                dec.eof              = 1'b1;
                block_remaining_next = 8'h00;
                zero_pending_next    = 1'b0;
                raw_seen_next        = 1'b0;
            end
            else
            begin
                raw_seen_next = 1'b1;
                if (block_remaining_reg == 8'h00)
                begin
                    dec.push             = zero_pending_reg;
                    zero_pending_next    = (wire_byte != CODE_MAX);
                    block_remaining_next = wire_byte - 8'd1;
                end
                else
                begin
                    dec.push             = 1'b1;
                    dec.data             = wire_byte;
                    block_remaining_next = block_remaining_reg - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_remaining_reg <= 8'h00;
            zero_pending_reg    <= 1'b0;
            raw_seen_reg        <= 1'b0;
        end
        else
        begin
            block_remaining_reg <= block_remaining_next;
            zero_pending_reg    <= zero_pending_next;
            raw_seen_reg        <= raw_seen_next;
        end
    end

endmodule

// ----- rtl/core/cobs_crc_check.sv -----
// Header capture, two-byte hold line, CRC and end-of-frame status.
// Depends on cobs_crc_pkg.
module cobs_crc_check
    import cobs_crc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  dec_t    dec,
    output logic    res_valid,
    output result_t res
);

    logic [8:0]  count_reg, count_next;
    logic [7:0]  hold0_reg, hold0_next;
    logic [7:0]  hold1_reg, hold1_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  len_reg, len_next;
    status_t     code;

    always_comb
    begin
        if (dec.empty)
            code = ST_EMPTY;
        else if (dec.trunc)
            code = ST_TRUNC;
        else if (count_reg < MIN_FRAME)
            code = ST_SHORT;
        else if (count_reg != ({1'b0, len_reg} + MIN_FRAME))
            code = ST_LEN;
        else if (crc_reg != {hold1_reg, hold0_reg})
            code = ST_CRC;
        else
            code = ST_OK;
    end

    always_comb
    begin
        count_next       = count_reg;
        hold0_next       = hold0_reg;
        hold1_next       = hold1_reg;
        crc_next         = crc_reg;
        seq_next         = seq_reg;
        cmd_next         = cmd_reg;
        len_next         = len_reg;
        res_valid        = 1'b0;
        res.is_status    = 1'b0;
        res.payload_byte = 8'h00;
        res.seq          = seq_reg;
        res.cmd          = cmd_reg;
        res.len          = len_reg;
        res.status       = ST_OK;
        if (dec.eof)
        begin
            res_valid     = 1'b1;
            res.is_status = 1'b1;
            res.status    = code;
            count_next    = 9'd0;
            hold0_next    = 8'h00;
            hold1_next    = 8'h00;
            crc_next      = CRC_INIT;
            seq_next      = 8'h00;
            cmd_next      = 8'h00;
            len_next      = 8'h00;
        end
        else if (dec.push)
        begin
            if (count_reg == 9'd0)
                seq_next = dec.data;
            if (count_reg == 9'd1)
                cmd_next = dec.data;
            if (count_reg == HDR_LAST)
                len_next = dec.data;
            if (count_reg >= HDR_LAST)
                crc_next = crc_byte(crc_reg, hold0_reg);
            if (count_reg >= MIN_FRAME)
            begin
                res_valid        = 1'b1;
                res.payload_byte = hold0_reg;
            end
            hold0_next = hold1_reg;
            hold1_next = dec.data;
            if (count_reg != COUNT_MAX)
                count_next = count_reg + 9'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 9'd0;
            hold0_reg <= 8'h00;
            hold1_reg <= 8'h00;
            crc_reg   <= CRC_INIT;
            seq_reg   <= 8'h00;
            cmd_reg   <= 8'h00;
            len_reg   <= 8'h00;
        end
        else
        begin
            count_reg <= count_next;
            hold0_reg <= hold0_next;
            hold1_reg <= hold1_next;
            crc_reg   <= crc_next;
            seq_reg   <= seq_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ----- rtl/core/cobs_crc_skid.sv -----
// Two-entry result queue that decouples the receiver from the decoder.
// Depends on cobs_crc_pkg.
module cobs_crc_skid
    import cobs_crc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_valid,
    input  result_t wr_data,
    output logic    wr_ready,
    output logic    rd_valid,
    input  logic    rd_ready,
    output result_t rd_data
);

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/cobs_crc_frame_decoder.sv -----
// Top level of the COBS frame decoder with CRC-16/CCITT-FALSE check.
// Depends on cobs_crc_pkg, cobs_crc_unstuff, cobs_crc_check and cobs_crc_skid.
//
// The input channel takes one wire byte per item on in_valid/in_ready; a zero
// byte ends a frame. The output channel gives on out_valid/out_ready either a
// payload byte (is_status low) or one end-of-frame status (is_status high)
// together with the header seq, cmd and len captured so far.
// An item's result, if any, is visible on the output in the cycle after
// acceptance, and a new byte can be accepted in every cycle while the queue is not full.
// The unstuffing, header, CRC byte update and status checks sit between the
// frame state registers and a two-entry result queue.
// Payload bytes leave before the frame check completes, so the receiver must
// drop them when the status that follows is not ok.
// Reset clears the frame state and empties the queue.
// When the receiver stalls, the queue fills and in_ready drops once both
// entries are held; no result is lost.
module cobs_crc_frame_decoder
    import cobs_crc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] wire_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_status,
    output logic [7:0] payload_byte,
    output logic [7:0] frame_seq,
    output logic [7:0] frame_cmd,
    output logic [7:0] frame_len,
    output logic [2:0] frame_status
);

    logic    step;
    dec_t    dec;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign step = in_valid && in_ready;

    cobs_crc_unstuff u_unstuff (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .wire_byte (wire_byte),
        .dec       (dec)
    );

    cobs_crc_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec       (dec),
        .res_valid (res_valid),
        .res       (res)
    );

    cobs_crc_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .wr_ready (in_ready),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_data  (out_res)
    );

    assign is_status    = out_res.is_status;
    assign payload_byte = out_res.payload_byte;
    assign frame_seq    = out_res.seq;
    assign frame_cmd    = out_res.cmd;
    assign frame_len    = out_res.len;
    assign frame_status = out_res.status;

`ifndef SYNTHESIS
    a_full_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled while no result is pending");

    a_delim_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        (step && wire_byte == 8'h00) |-> (res_valid && res.is_status))
        else $error("delimiter accepted without a status result");

    a_status_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_status) |-> (payload_byte == 8'h00))
        else $error("status result carries a payload byte");

    a_payload_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_status) |-> (frame_status == ST_OK))
        else $error("payload result carries a status code");
`endif

endmodule

// ----- sim/cobs_crc_frame_decoder_tb.sv -----
// Self-checking testbench for cobs_crc_frame_decoder: a directed table, then random COBS
// frames with random handshake gaps, all scored against an in-bench frame decoder.
// Depends on cobs_crc_pkg and the cobs_crc_frame_decoder RTL.
`timescale 1ns / 100ps

module cobs_crc_frame_decoder_tb;
    import cobs_crc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 110;

    typedef struct packed {
        logic       is_status;
        logic [7:0] pb;
        logic [7:0] seq;
        logic [7:0] cmd;
        logic [7:0] len;
        status_t    st;
    } frame_result_t;

    typedef struct packed {
        logic [7:0]    b;
        logic          typed;
        frame_result_t want;
    } stim_row_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_LEN,
        FR_CUT,
        FR_NOISE,
        FR_EMPTY
    } frame_kind_t;

    localparam frame_result_t NO_TYPED = '0;

    localparam stim_row_t DIRECTED [0:17] = '{
        {8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, ST_EMPTY},
        {8'hFF, 1'b0, NO_TYPED},
        {8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, ST_TRUNC},
        {8'h01, 1'b0, NO_TYPED},
        {8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, ST_SHORT},
        {8'h03, 1'b0, NO_TYPED},
        {8'h11, 1'b0, NO_TYPED},
        {8'h00, 1'b1, 1'b1, 8'h00, 8'h11, 8'h00, 8'h00, ST_TRUNC},
        {8'h02, 1'b0, NO_TYPED},
        {8'h05, 1'b0, NO_TYPED},
        {8'h00, 1'b1, 1'b1, 8'h00, 8'h05, 8'h00, 8'h00, ST_SHORT},
        {8'h06, 1'b0, NO_TYPED},
        {8'hAA, 1'b0, NO_TYPED},
        {8'hBB, 1'b0, NO_TYPED},
        {8'h01, 1'b0, NO_TYPED},
        {8'h01, 1'b0, NO_TYPED},
        {8'h02, 1'b0, NO_TYPED},
        {8'h00, 1'b1, 1'b1, 8'h00, 8'hAA, 8'hBB, 8'h01, ST_LEN}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] wire_byte;
    logic       out_valid;
    logic       out_ready;
    logic       is_status;
    logic [7:0] payload_byte;
    logic [7:0] frame_seq;
    logic [7:0] frame_cmd;
    logic [7:0] frame_len;
    logic [2:0] frame_status;

    stim_row_t     wire_items[$];
    frame_result_t expected_results[$];
    int            accept_idx;
    int            mismatch_count;
    int            cycle_count;

    logic [7:0]  blk_left;
    logic        zero_owed;
    logic [8:0]  dec_count;
    logic [7:0]  delay_line [0:1];
    logic [15:0] crc_run;
    logic [7:0]  cur_seq;
    logic [7:0]  cur_cmd;
    logic [7:0]  cur_len;
    logic        frame_started;

    cobs_crc_frame_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .wire_byte    (wire_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_status    (is_status),
        .payload_byte (payload_byte),
        .frame_seq    (frame_seq),
        .frame_cmd    (frame_cmd),
        .frame_len    (frame_len),
        .frame_status (frame_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c;
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[14:0], 1'b0} ^ ((r[15] ^ d[i]) ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic restart_frame();
        blk_left      = 8'h00;
        zero_owed     = 1'b0;
        dec_count     = 9'd0;
        delay_line[0] = 8'h00;
        delay_line[1] = 8'h00;
        crc_run       = CRC_INIT;
        cur_seq       = 8'h00;
        cur_cmd       = 8'h00;
        cur_len       = 8'h00;
        frame_started = 1'b0;
    endtask

    task automatic take_decoded_byte(input logic [7:0] d);
        logic [7:0]    leaving;
        frame_result_t r;
        leaving = delay_line[0];
        case (dec_count)
            9'd0: cur_seq = d;
            9'd1: cur_cmd = d;
            9'd2: cur_len = d;
            default: ;
        endcase
        if (dec_count >= HDR_LAST)
        begin
            crc_run = crc16_next(crc_run, leaving);
            if (dec_count >= MIN_FRAME)
            begin
                r = {1'b0, leaving, cur_seq, cur_cmd, cur_len, ST_OK};
                expected_results.insert(expected_results.size(), r);
            end
        end
        delay_line[0] = delay_line[1];
        delay_line[1] = d;
        if (dec_count != COUNT_MAX)
            dec_count = dec_count + 9'd1;
    endtask

    task automatic decode_wire_byte(input logic [7:0] b);
        status_t       st;
        frame_result_t r;
        if (b == 8'h00)
        begin
            if (!frame_started)
                st = ST_EMPTY;
            else if (blk_left != 8'h00)
                st = ST_TRUNC;
            else if (dec_count < MIN_FRAME)
                st = ST_SHORT;
            else if (dec_count != {1'b0, cur_len} + MIN_FRAME)
                st = ST_LEN;
            else if (crc_run != {delay_line[1], delay_line[0]})
                st = ST_CRC;
            else
                st = ST_OK;
            r = {1'b1, 8'h00, cur_seq, cur_cmd, cur_len, st};
            expected_results.insert(expected_results.size(), r);
            restart_frame();
        end
        else
        begin
            frame_started = 1'b1;
            if (blk_left == 8'h00)
            begin
                if (zero_owed)
                    take_decoded_byte(8'h00);
                zero_owed = (b != CODE_MAX);
                blk_left  = b - 8'h01;
            end
            else
            begin
                take_decoded_byte(b);
                blk_left = blk_left - 8'h01;
            end
        end
    endtask

    task automatic add_frame(input frame_kind_t kind, input int plen, input bit no_zeros);
        logic [7:0]  plain[$];
        logic [7:0]  coded[$];
        logic [7:0]  blk[$];
        logic [15:0] crc;
        logic [7:0]  d;
        bit          last;
        int          cut;
        stim_row_t   row;
        if (kind == FR_NOISE)
        begin
            repeat ($urandom_range(1, 8)) coded.insert(coded.size(), 8'($urandom_range(0, 255)));
        end
        else if (kind != FR_EMPTY)
        begin
            plain.insert(plain.size(), 8'($urandom_range(0, 255)));
            plain.insert(plain.size(), 8'($urandom_range(0, 255)));
            if (kind == FR_BAD_LEN)
                plain.insert(plain.size(), 8'(plen[7:0] + $urandom_range(1, 255)));
            else
                plain.insert(plain.size(), plen[7:0]);
            for (int i = 0; i < plen; i++)
            begin
                if (no_zeros || ($urandom_range(0, 3) != 0))
                    d = 8'($urandom_range(1, 255));
                else
                    d = 8'h00;
                plain.insert(plain.size(), d);
            end
            crc = CRC_INIT;
            foreach (plain[i])
                crc = crc16_next(crc, plain[i]);
            if (kind == FR_BAD_CRC)
                crc = crc ^ 16'($urandom_range(1, 65535));
            plain.insert(plain.size(), crc[7:0]);
            plain.insert(plain.size(), crc[15:8]);
            for (int i = 0; i <= plain.size(); i++)
            begin
                last = (i == plain.size());
                if (!last && plain[i] != 8'h00)
                    blk.insert(blk.size(), plain[i]);
                if (last || plain[i] == 8'h00 || blk.size() == 254)
                begin
                    coded.insert(coded.size(), 8'(blk.size() + 1));
                    foreach (blk[j])
                        coded.insert(coded.size(), blk[j]);
                    blk.delete();
                end
            end
            if (kind == FR_CUT)
            begin
                cut = $urandom_range(1, 3);
                while (cut > 0 && coded.size() > 1)
                begin
                    coded.delete(coded.size() - 1);
                    cut--;
                end
            end
        end
        foreach (coded[i])
        begin
            row = {coded[i], 1'b0, NO_TYPED};
            wire_items.insert(wire_items.size(), row);
        end
        row = {8'h00, 1'b0, NO_TYPED};
        wire_items.insert(wire_items.size(), row);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : scoreboard
        stim_row_t     row;
        frame_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                row = wire_items[accept_idx];
                accept_idx++;
                decode_wire_byte(wire_byte);
                if (row.typed)
                    expected_results[expected_results.size() - 1] = row.want;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item is_status=%0b byte=%02h st=%0d",
                                              is_status, payload_byte, frame_status));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (is_status !== want.is_status)
                        report_mismatch($sformatf("is_status %0b, want %0b",
                                                  is_status, want.is_status));
                    if (payload_byte !== want.pb)
                        report_mismatch($sformatf("payload_byte %02h, want %02h",
                                                  payload_byte, want.pb));
                    if (frame_seq !== want.seq)
                        report_mismatch($sformatf("frame_seq %02h, want %02h",
                                                  frame_seq, want.seq));
                    if (frame_cmd !== want.cmd)
                        report_mismatch($sformatf("frame_cmd %02h, want %02h",
                                                  frame_cmd, want.cmd));
                    if (frame_len !== want.len)
                        report_mismatch($sformatf("frame_len %02h, want %02h",
                                                  frame_len, want.len));
                    if (frame_status !== want.st)
                        report_mismatch($sformatf("frame_status %0d, want %0d",
                                                  frame_status, want.st));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : receiver
        int rx_cyc;
        out_ready <= 1'b0;
        rx_cyc = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            rx_cyc++;
            if (rx_cyc == 150)
            begin
                repeat (64)
                begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                    rx_cyc++;
                end
            end
            if (rx_cyc >= 500 && rx_cyc < 800)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 28);
        end
    end

    initial
    begin : sender
        int          base;
        frame_kind_t kind;
        int          roll;
        int          plen;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        wire_byte <= 8'h00;
        accept_idx     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        restart_frame();

        foreach (DIRECTED[i])
            wire_items.insert(wire_items.size(), DIRECTED[i]);
        add_frame(FR_GOOD, 0, 1'b0);
        add_frame(FR_BAD_CRC, 4, 1'b0);
        add_frame(FR_GOOD, 255, 1'b1);
        base = wire_items.size();
        while (wire_items.size() - base < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 66)
                kind = FR_GOOD;
            else if (roll < 74)
                kind = FR_BAD_CRC;
            else if (roll < 81)
                kind = FR_BAD_LEN;
            else if (roll < 88)
                kind = FR_CUT;
            else if (roll < 95)
                kind = FR_NOISE;
            else
                kind = FR_EMPTY;
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            add_frame(kind, plen, $urandom_range(0, 4) == 0);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (wire_items[i])
        begin
            if (i < 200 || i >= 350)
            begin
                while ($urandom_range(0, 99) < 28)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                end
            end
            in_valid  <= 1'b1;
            wire_byte <= wire_items[i].b;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/cobs_crc_pkg.sv
rtl/core/cobs_crc_unstuff.sv
rtl/core/cobs_crc_check.sv
rtl/core/cobs_crc_skid.sv
rtl/core/cobs_crc_frame_decoder.sv
sim/cobs_crc_frame_decoder_tb.sv
